[hdl/imsu_pkg.sv]
// Shared types, codes, constants and the exponential lookup table for the Ising site update.
package imsu_pkg;

    // default lattice side
    localparam int SIDE_DEF = 10;

    // item operation codes
    localparam logic [1:0] FUNC_WR_SPIN  = 2'd0;
    localparam logic [1:0] FUNC_WR_XBOND = 2'd1;
    localparam logic [1:0] FUNC_WR_YBOND = 2'd2;
    localparam logic [1:0] FUNC_FLIP     = 2'd3;

    // stream and register port widths
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 32;

    // register map: word index taken from paddr[2]
    localparam logic REG_BETA = 1'b0;
    localparam logic [15:0] BETA_RESET = 16'd4096;

    // exp(-k/16) table in Q0.16, built from a Q0.32 decay factor
    localparam int EXP_ENTRIES = 256;
    localparam logic [63:0] DECAY_Q32 = 64'd4034748382;

    typedef logic [15:0] t_exp_tab [EXP_ENTRIES];

    function automatic t_exp_tab build_exp_table();
        t_exp_tab   tab;
        logic [63:0] acc;
        logic [63:0] v;
        acc = 64'd1 << 32;
        for (int k = 0; k < EXP_ENTRIES; k++) begin
            v = (acc + 64'd32768) >> 16;
            tab[k] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
            acc = (acc * DECAY_Q32 + (64'd1 << 31)) >> 32;
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TABLE = build_exp_table();

    // one input item
    typedef struct packed {
        logic [1:0]         func;
        logic [3:0]         row;
        logic [3:0]         column;
        logic               spin_in;
        logic signed [15:0] coupling_in;
        logic [15:0]        random_draw;
    } t_item;

    // one result item
    typedef struct packed {
        logic               accepted;
        logic               spin_out;
        logic signed [18:0] energy_change;
    } t_result;

endpackage

[hdl/ising_metropolis_site_update.sv]
// An accepted transfer is captured with its row reads in the item stage; its result
// goes to the result register once that is free. One item per cycle while the output
// takes results; the lattice row read is registered, then field, exp lookup and test.
// Back-to-back items on the same rows see earlier updates through a forwarding register.
// Reset (synchronous, active low) empties the pipeline, sets beta to 4096 and clears
// the row valid bits, so every spin reads +1 and every coupling 0 at once.
module ising_metropolis_site_update import imsu_pkg::*; #(
    parameter int SIDE = SIDE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // [3:0] row, [7:4] column, [8] spin_in, [24:9] coupling_in, [40:25] random_draw
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // [1:0] func
    input  logic [S_TUSER_W-1:0] i_s_tuser,
    // master stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [0] accepted, [1] spin_out, [20:2] energy_change
    output logic [M_TDATA_W-1:0] o_m_tdata,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [CFG_AW-1:0]    paddr,
    input  logic [CFG_DW-1:0]    pwdata,
    output logic [CFG_DW-1:0]    prdata,
    output logic                 pready
);

    localparam int IW = $clog2(SIDE);

    t_item   s_item;
    t_item   r_item;
    logic    r_s1_vld;
    logic    r_out_vld;
    t_result r_out;
    t_result upd_result;
    logic    s_acc;
    logic    s1_adv;

    logic [IW-1:0] in_row;
    logic [IW-1:0] in_rm;
    logic [IW-1:0] in_rp;
    logic [15:0]   beta;

    logic                  upd_wr_en;
    logic [SIDE-1:0]       upd_spin;
    logic [SIDE-1:0][15:0] upd_jx;
    logic [SIDE-1:0][15:0] upd_jy;
    logic [SIDE-1:0]       row_spin_rm;
    logic [SIDE-1:0]       row_spin_r;
    logic [SIDE-1:0]       row_spin_rp;
    logic [SIDE-1:0][15:0] row_jx_r;
    logic [SIDE-1:0][15:0] row_jx_rm;
    logic [SIDE-1:0][15:0] row_jy_r;

    // unpack the incoming transfer
    assign s_item.func        = i_s_tuser[1:0];
    assign s_item.row         = i_s_tdata[3:0];
    assign s_item.column      = i_s_tdata[7:4];
    assign s_item.spin_in     = i_s_tdata[8];
    assign s_item.coupling_in = i_s_tdata[24:9];
    assign s_item.random_draw = i_s_tdata[40:25];

    // handshake
    assign s1_adv     = r_s1_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_s1_vld || s1_adv;
    assign s_acc      = i_s_tvalid && o_s_tready;

    // rows to read: own row and its periodic neighbors
    assign in_row = IW'(s_item.row);
    assign in_rp  = (in_row == IW'(SIDE - 1)) ? '0 : in_row + IW'(1);
    assign in_rm  = (in_row == '0) ? IW'(SIDE - 1) : in_row - IW'(1);

    imsu_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_beta  (beta)
    );

    imsu_store #(.SIDE(SIDE)) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (s_acc),
        .i_rd_row  (in_row),
        .i_rd_rm   (in_rm),
        .i_rd_rp   (in_rp),
        .i_wr_en   (s1_adv && upd_wr_en),
        .i_wr_row  (IW'(r_item.row)),
        .i_wr_spin (upd_spin),
        .i_wr_jx   (upd_jx),
        .i_wr_jy   (upd_jy),
        .o_spin_rm (row_spin_rm),
        .o_spin_r  (row_spin_r),
        .o_spin_rp (row_spin_rp),
        .o_jx_r    (row_jx_r),
        .o_jx_rm   (row_jx_rm),
        .o_jy_r    (row_jy_r)
    );

    imsu_update #(.SIDE(SIDE)) u_update (
        .i_item    (r_item),
        .i_beta    (beta),
        .i_spin_rm (row_spin_rm),
        .i_spin_r  (row_spin_r),
        .i_spin_rp (row_spin_rp),
        .i_jx_r    (row_jx_r),
        .i_jx_rm   (row_jx_rm),
        .i_jy_r    (row_jy_r),
        .o_result  (upd_result),
        .o_wr_en   (upd_wr_en),
        .o_wr_spin (upd_spin),
        .o_wr_jx   (upd_jx),
        .o_wr_jy   (upd_jy)
    );

    // item stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    // capture the item with its row reads
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_item <= s_item;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    // load the result
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out <= upd_result;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {3'b000, r_out.energy_change, r_out.spin_out, r_out.accepted};

endmodule

[hdl/imsu_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module imsu_ram import imsu_pkg::*; #(
    parameter int WIDTH = 1,
    parameter int DEPTH = SIDE_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/imsu_cfg.sv]
// Configuration register block: inverse temperature on an APB-style port.
module imsu_cfg import imsu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output logic [15:0]       o_beta
);

    logic [15:0] r_beta;
    logic        sel_beta;

    assign sel_beta = (paddr[2] == REG_BETA);

    // take a register write in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta <= BETA_RESET;
        end else if (psel && penable && pwrite && pready && sel_beta) begin
            r_beta <= pwdata[15:0];
        end
    end

    // read back
    assign prdata = sel_beta ? {16'd0, r_beta} : '0;
    assign pready = 1'b1;
    assign o_beta = r_beta;

endmodule

[hdl/imsu_store.sv]
// Lattice storage: row-wide spin and coupling memories, row valid bits and write forwarding.
module imsu_store import imsu_pkg::*; #(
    parameter int SIDE = SIDE_DEF,
    localparam int IW = $clog2(SIDE)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_rd_en,
    input  logic [IW-1:0]          i_rd_row,
    input  logic [IW-1:0]          i_rd_rm,
    input  logic [IW-1:0]          i_rd_rp,
    input  logic                   i_wr_en,
    input  logic [IW-1:0]          i_wr_row,
    input  logic [SIDE-1:0]        i_wr_spin,
    input  logic [SIDE-1:0][15:0]  i_wr_jx,
    input  logic [SIDE-1:0][15:0]  i_wr_jy,
    output logic [SIDE-1:0]        o_spin_rm,
    output logic [SIDE-1:0]        o_spin_r,
    output logic [SIDE-1:0]        o_spin_rp,
    output logic [SIDE-1:0][15:0]  o_jx_r,
    output logic [SIDE-1:0][15:0]  o_jx_rm,
    output logic [SIDE-1:0][15:0]  o_jy_r
);

    localparam int JW = 16 * SIDE;

    logic [SIDE-1:0] ram_spin_rm;
    logic [SIDE-1:0] ram_spin_r;
    logic [SIDE-1:0] ram_spin_rp;
    logic [JW-1:0]   ram_jx_r;
    logic [JW-1:0]   ram_jx_rm;
    logic [JW-1:0]   ram_jy_r;

    logic [SIDE-1:0] r_row_vld;
    logic            r_vld_rm;
    logic            r_vld_r;
    logic            r_vld_rp;
    logic            r_hit_rm;
    logic            r_hit_r;
    logic            r_hit_rp;

    logic [SIDE-1:0]       r_wb_spin;
    logic [SIDE-1:0][15:0] r_wb_jx;
    logic [SIDE-1:0][15:0] r_wb_jy;

    // spin rows: one copy per row read in the same cycle
    imsu_ram #(.WIDTH(SIDE), .DEPTH(SIDE)) u_spin_rm (
        .i_clk   (i_clk),
        .i_we    (i_wr_en),
        .i_waddr (i_wr_row),
        .i_wdata (i_wr_spin),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_rm),
        .o_rdata (ram_spin_rm)
    );

    imsu_ram #(.WIDTH(SIDE), .DEPTH(SIDE)) u_spin_r (
        .i_clk   (i_clk),
        .i_we    (i_wr_en),
        .i_waddr (i_wr_row),
        .i_wdata (i_wr_spin),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_row),
        .o_rdata (ram_spin_r)
    );

    imsu_ram #(.WIDTH(SIDE), .DEPTH(SIDE)) u_spin_rp (
        .i_clk   (i_clk),
        .i_we    (i_wr_en),
        .i_waddr (i_wr_row),
        .i_wdata (i_wr_spin),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_rp),
        .o_rdata (ram_spin_rp)
    );

    // x-bond rows: own row and the row above
    imsu_ram #(.WIDTH(JW), .DEPTH(SIDE)) u_jx_r (
        .i_clk   (i_clk),
        .i_we    (i_wr_en),
        .i_waddr (i_wr_row),
        .i_wdata (i_wr_jx),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_row),
        .o_rdata (ram_jx_r)
    );

    imsu_ram #(.WIDTH(JW), .DEPTH(SIDE)) u_jx_rm (
        .i_clk   (i_clk),
        .i_we    (i_wr_en),
        .i_waddr (i_wr_row),
        .i_wdata (i_wr_jx),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_rm),
        .o_rdata (ram_jx_rm)
    );

    // y-bond row: both y-bonds of a site lie in its own row
    imsu_ram #(.WIDTH(JW), .DEPTH(SIDE)) u_jy_r (
        .i_clk   (i_clk),
        .i_we    (i_wr_en),
        .i_waddr (i_wr_row),
        .i_wdata (i_wr_jy),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_row),
        .o_rdata (ram_jy_r)
    );

    // mark rows written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_wr_en) begin
            r_row_vld[i_wr_row] <= 1'b1;
        end
    end

    // sample row validity and same-edge write hits with each read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_rm <= 1'b0;
            r_vld_r  <= 1'b0;
            r_vld_rp <= 1'b0;
            r_hit_rm <= 1'b0;
            r_hit_r  <= 1'b0;
            r_hit_rp <= 1'b0;
        end else if (i_rd_en) begin
            r_vld_rm <= r_row_vld[i_rd_rm];
            r_vld_r  <= r_row_vld[i_rd_row];
            r_vld_rp <= r_row_vld[i_rd_rp];
            r_hit_rm <= i_wr_en && (i_wr_row == i_rd_rm);
            r_hit_r  <= i_wr_en && (i_wr_row == i_rd_row);
            r_hit_rp <= i_wr_en && (i_wr_row == i_rd_rp);
        end
    end

    // hold the last written row for forwarding
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_wb_spin <= i_wr_spin;
            r_wb_jx   <= i_wr_jx;
            r_wb_jy   <= i_wr_jy;
        end
    end

    // pick forwarded, stored or reset row contents
    assign o_spin_rm = r_hit_rm ? r_wb_spin : (r_vld_rm ? ram_spin_rm : '1);
    assign o_spin_r  = r_hit_r  ? r_wb_spin : (r_vld_r  ? ram_spin_r  : '1);
    assign o_spin_rp = r_hit_rp ? r_wb_spin : (r_vld_rp ? ram_spin_rp : '1);
    assign o_jx_r    = r_hit_r  ? r_wb_jx   : (r_vld_r  ? ram_jx_r    : '0);
    assign o_jx_rm   = r_hit_rm ? r_wb_jx   : (r_vld_rm ? ram_jx_rm   : '0);
    assign o_jy_r    = r_hit_r  ? r_wb_jy   : (r_vld_r  ? ram_jy_r    : '0);

endmodule

[hdl/imsu_update.sv]
// Site update logic: local field, energy change, Metropolis test and row write-back data.
module imsu_update import imsu_pkg::*; #(
    parameter int SIDE = SIDE_DEF,
    localparam int IW = $clog2(SIDE)
) (
    input  t_item                  i_item,
    input  logic [15:0]            i_beta,
    input  logic [SIDE-1:0]        i_spin_rm,
    input  logic [SIDE-1:0]        i_spin_r,
    input  logic [SIDE-1:0]        i_spin_rp,
    input  logic [SIDE-1:0][15:0]  i_jx_r,
    input  logic [SIDE-1:0][15:0]  i_jx_rm,
    input  logic [SIDE-1:0][15:0]  i_jy_r,
    output t_result                o_result,
    output logic                   o_wr_en,
    output logic [SIDE-1:0]        o_wr_spin,
    output logic [SIDE-1:0][15:0]  o_wr_jx,
    output logic [SIDE-1:0][15:0]  o_wr_jy
);

    localparam int CW = ($clog2(SIDE + 1) > 4) ? $clog2(SIDE + 1) : 4;

    logic [IW-1:0]       c;
    logic [IW-1:0]       cp;
    logic [IW-1:0]       cm;
    logic                in_range;
    logic                is_flip;
    logic                s;
    logic signed [17:0]  t_down;
    logic signed [17:0]  t_up;
    logic signed [17:0]  t_right;
    logic signed [17:0]  t_left;
    logic signed [18:0]  field_sum;
    logic signed [19:0]  d2;
    logic signed [19:0]  de;
    logic                de_pos;
    logic [34:0]         prod;
    logic                small_k;
    logic [15:0]         w;
    logic                acc;
    logic                sat;

    // coupling times neighbor spin
    function automatic logic signed [17:0] bond_term(input logic sp,
                                                     input logic signed [15:0] j);
        logic signed [17:0] jw;
        jw = 18'(j);
        return sp ? jw : -jw;
    endfunction

    // address checks and periodic neighbors
    assign in_range = (CW'(i_item.row) < CW'(SIDE)) && (CW'(i_item.column) < CW'(SIDE));
    assign is_flip  = (i_item.func == FUNC_FLIP);
    assign c  = IW'(i_item.column);
    assign cp = (c == IW'(SIDE - 1)) ? '0 : c + IW'(1);
    assign cm = (c == '0) ? IW'(SIDE - 1) : c - IW'(1);
    assign s  = i_spin_r[c];

    // local field
    assign t_down    = bond_term(i_spin_rp[c], signed'(i_jx_r[c]));
    assign t_up      = bond_term(i_spin_rm[c], signed'(i_jx_rm[c]));
    assign t_right   = bond_term(i_spin_r[cp], signed'(i_jy_r[c]));
    assign t_left    = bond_term(i_spin_r[cm], signed'(i_jy_r[cm]));
    assign field_sum = 19'(t_down) + 19'(t_up) + 19'(t_right) + 19'(t_left);

    // dE = 2 * s * field
    assign d2     = {field_sum, 1'b0};
    assign de     = s ? d2 : -d2;
    assign de_pos = !de[19] && (de != '0);

    // Boltzmann weight lookup in steps of 1/16, zero past the table end
    assign prod    = 35'(de[18:0]) * 35'(i_beta);
    assign small_k = (prod[34:28] == '0);
    assign w       = EXP_TABLE[prod[27:20]];
    assign acc     = in_range && is_flip && (!de_pos || (small_k && (w > i_item.random_draw)));

    // clip the reported energy at the top of the output range
    assign sat = (de[19:18] == 2'b01);

    // row write-back contents
    always_comb begin
        o_wr_spin = i_spin_r;
        o_wr_jx   = i_jx_r;
        o_wr_jy   = i_jy_r;
        unique case (i_item.func)
            FUNC_WR_SPIN:  o_wr_spin[c] = i_item.spin_in;
            FUNC_WR_XBOND: o_wr_jx[c]   = i_item.coupling_in;
            FUNC_WR_YBOND: o_wr_jy[c]   = i_item.coupling_in;
            FUNC_FLIP:     o_wr_spin[c] = acc ? ~s : s;
            default:       o_wr_spin[c] = s;
        endcase
    end

    assign o_wr_en = in_range;

    // result fields, all zero for an address off the lattice
    always_comb begin
        o_result.accepted      = acc;
        o_result.spin_out      = in_range && o_wr_spin[c];
        o_result.energy_change = '0;
        if (in_range && is_flip) begin
            o_result.energy_change = sat ? 19'sh3FFFF : de[18:0];
        end
    end

endmodule

[hdl/imsu_checker.sv]
// Port-level checks for the Ising site update, bound to the top level.
module imsu_checker import imsu_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // with the result register empty the block takes input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // a rejected flip always carries a positive energy change
    a_reject_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] && (o_m_tdata[20:2] != '0) |-> !o_m_tdata[20])
        else $error("rejection with non-positive energy change");

endmodule

bind ising_metropolis_site_update imsu_checker u_imsu_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

[sim/tb_ising_metropolis_site_update.sv]
// Self-checking testbench for the Ising Metropolis site update block.
module tb_ising_metropolis_site_update;
    import imsu_pkg::*;

    localparam int LAT           = SIDE_DEF;
    localparam int N_PHASES      = 7;
    localparam int RAND_PER_PHASE = 135;
    localparam int IDLE_PCT      = 37;
    localparam longint unsigned DECAY_STEP = 64'd4034748382;
    localparam logic [CFG_AW-1:0] BETA_ADDR = {REG_BETA, 2'b00};

    // Scoreboard: keeps a private copy of the lattice and predicts each result
    class site_update_scoreboard;
        bit                      spin_up [LAT][LAT];
        shortint                 x_bond [LAT][LAT];
        shortint                 y_bond [LAT][LAT];
        logic [15:0]             beta;
        logic [15:0]             exp_steps [256];
        t_result                 expected_updates [$];
        int                      errors;

        function new();
            longint unsigned acc;
            longint unsigned v;
            for (int r = 0; r < LAT; r++) begin
                for (int c = 0; c < LAT; c++) begin
                    spin_up[r][c] = 1'b1;
                    x_bond[r][c]  = 0;
                    y_bond[r][c]  = 0;
                end
            end
            beta   = BETA_RESET;
            errors = 0;
            // exp(-k/16) in Q0.16 by repeated decay in Q0.32
            acc = 64'd1 << 32;
            for (int k = 0; k < 256; k++) begin
                v = (acc + 64'd32768) >> 16;
                exp_steps[k] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
                acc = (acc * DECAY_STEP + (64'd1 << 31)) >> 32;
            end
        endfunction

        function int spin_of(int r, int c);
            return spin_up[r][c] ? 1 : -1;
        endfunction

        // Apply one accepted item to the lattice and queue its expected result
        function void note_item(t_item it);
            t_result         want;
            int              r, c, rp, rm, cp, cm;
            int              sum, de;
            longint unsigned p;
            bit              acc_bit;
            want = '0;
            if (it.row >= LAT || it.column >= LAT) begin
                expected_updates.push_back(want);
                return;
            end
            r = it.row;
            c = it.column;
            de = 0;
            acc_bit = 1'b0;
            case (it.func)
                FUNC_WR_SPIN:  spin_up[r][c] = it.spin_in;
                FUNC_WR_XBOND: x_bond[r][c] = shortint'(it.coupling_in);
                FUNC_WR_YBOND: y_bond[r][c] = shortint'(it.coupling_in);
                FUNC_FLIP: begin
                    rp = (r + 1 == LAT) ? 0 : r + 1;
                    rm = (r == 0) ? LAT - 1 : r - 1;
                    cp = (c + 1 == LAT) ? 0 : c + 1;
                    cm = (c == 0) ? LAT - 1 : c - 1;
                    sum = x_bond[r][c] * spin_of(rp, c) + x_bond[rm][c] * spin_of(rm, c)
                        + y_bond[r][c] * spin_of(r, cp) + y_bond[r][cm] * spin_of(r, cm);
                    de = 2 * spin_of(r, c) * sum;
                    if (de <= 0) begin
                        acc_bit = 1'b1;
                    end else begin
                        p = longint'(de) * longint'(beta);
                        if ((p >> 20) < 256 && exp_steps[p >> 20] > it.random_draw)
                            acc_bit = 1'b1;
                    end
                    if (acc_bit)
                        spin_up[r][c] = !spin_up[r][c];
                    // saturate the reported value only
                    if (de > 262143)
                        de = 262143;
                end
                default: ;
            endcase
            want.accepted      = acc_bit;
            want.spin_out      = spin_up[r][c];
            want.energy_change = de[18:0];
            expected_updates.push_back(want);
        endfunction

        // Compare one result with the oldest expectation
        function void check_result(t_result got);
            t_result want;
            if (expected_updates.size() == 0) begin
                $error("result with no item outstanding: %h", got);
                errors++;
                return;
            end
            want = expected_updates.pop_front();
            if (got.accepted !== want.accepted) begin
                $error("accepted: expected %0d, actual %0d", want.accepted, got.accepted);
                errors++;
            end
            if (got.spin_out !== want.spin_out) begin
                $error("spin_out: expected %0d, actual %0d", want.spin_out, got.spin_out);
                errors++;
            end
            if (got.energy_change !== want.energy_change) begin
                $error("energy_change: expected %0d, actual %0d",
                       want.energy_change, got.energy_change);
                errors++;
            end
        endfunction

        function int pending();
            return expected_updates.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [3:0] row, [7:4] column, [8] spin_in, [24:9] coupling_in, [40:25] random_draw
    logic [S_TDATA_W-1:0] s_tdata = '0;
    // [1:0] func
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [0] accepted, [1] spin_out, [20:2] energy_change
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [CFG_AW-1:0]    paddr = '0;
    logic [CFG_DW-1:0]    pwdata = '0;
    logic [CFG_DW-1:0]    prdata;
    logic                 pready;
    logic                 steady = 1'b0;

    site_update_scoreboard sb;

    ising_metropolis_site_update u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Stall the result side at random, except in the steady phase
    always @(posedge i_clk) begin
        m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Note every input transfer
    always @(posedge i_clk) begin
        t_item it_seen;
        it_seen.func        = s_tuser[1:0];
        it_seen.row         = s_tdata[3:0];
        it_seen.column      = s_tdata[7:4];
        it_seen.spin_in     = s_tdata[8];
        it_seen.coupling_in = s_tdata[24:9];
        it_seen.random_draw = s_tdata[40:25];
        if (i_rst_n && s_tvalid && s_tready)
            sb.note_item(it_seen);
    end

    // Check every result transfer
    always @(posedge i_clk) begin
        t_result got;
        got.accepted      = m_tdata[0];
        got.spin_out      = m_tdata[1];
        got.energy_change = m_tdata[20:2];
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_result(got);
    end

    function automatic t_item make_item(logic [1:0] func, int row, int col, bit spin,
                                        int coupling, int draw);
        t_item it;
        it.func        = func;
        it.row         = row[3:0];
        it.column      = col[3:0];
        it.spin_in     = spin;
        it.coupling_in = coupling[15:0];
        it.random_draw = draw[15:0];
        return it;
    endfunction

    // Cluster addresses around the wrap corner so flips meet fresh writes
    function automatic int pick_index();
        int sel;
        sel = $urandom_range(0, 2);
        if ($urandom_range(0, 1) == 0)
            return (sel == 0) ? LAT - 1 : sel - 1;
        return $urandom_range(0, LAT - 1);
    endfunction

    function automatic t_item random_item();
        t_item it;
        int    w;
        w = $urandom_range(0, 99);
        it.func = (w < 15) ? FUNC_WR_SPIN : (w < 30) ? FUNC_WR_XBOND :
                  (w < 45) ? FUNC_WR_YBOND : FUNC_FLIP;
        it.row    = 4'(pick_index());
        it.column = 4'(pick_index());
        // drop a few items outside the lattice
        w = $urandom_range(0, 99);
        if (w < 3)
            it.row = 4'($urandom_range(LAT, 15));
        else if (w < 6)
            it.column = 4'($urandom_range(LAT, 15));
        it.spin_in = 1'($urandom_range(0, 1));
        w = $urandom_range(0, 99);
        if (w < 10)
            it.coupling_in = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        else if (w < 65)
            it.coupling_in = $urandom_range(0, 1) ? 16'($urandom_range(0, 2047))
                                                  : -16'($urandom_range(0, 2047));
        else
            it.coupling_in = 16'($urandom());
        w = $urandom_range(0, 99);
        it.random_draw = (w < 3) ? 16'h0000 : (w < 6) ? 16'hFFFF : 16'($urandom());
        return it;
    endfunction

    // Offer one item and hold it until the transfer
    task automatic send_item(t_item it);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.func;
        s_tdata  <= {7'd0, it.random_draw, it.coupling_in, it.spin_in, it.column, it.row};
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic write_beta(logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BETA_ADDR;
        pwdata  <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.beta = value;
    endtask

    task automatic wait_drained();
        // let the monitors take the transfers of the current edge first
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_directed();
        t_item dir [$];
        // zero field: flip always taken, then flipped back
        dir.push_back(make_item(FUNC_FLIP, 0, 0, 0, 0, 16'hFFFF));
        dir.push_back(make_item(FUNC_FLIP, 0, 0, 0, 0, 0));
        // strongest aligned field: saturated positive change, rejected at draw zero
        dir.push_back(make_item(FUNC_WR_XBOND, 0, 0, 0, -32768, 0));
        dir.push_back(make_item(FUNC_WR_XBOND, LAT - 1, 0, 0, -32768, 0));
        dir.push_back(make_item(FUNC_WR_YBOND, 0, 0, 0, -32768, 0));
        dir.push_back(make_item(FUNC_WR_YBOND, 0, LAT - 1, 0, -32768, 0));
        dir.push_back(make_item(FUNC_WR_SPIN, 1, 0, 0, 0, 0));
        dir.push_back(make_item(FUNC_WR_SPIN, LAT - 1, 0, 0, 0, 0));
        dir.push_back(make_item(FUNC_WR_SPIN, 0, 1, 0, 0, 0));
        dir.push_back(make_item(FUNC_WR_SPIN, 0, LAT - 1, 0, 0, 0));
        dir.push_back(make_item(FUNC_FLIP, 0, 0, 1, 32767, 0));
        // most negative change: always taken
        dir.push_back(make_item(FUNC_WR_SPIN, 0, 0, 0, 0, 0));
        dir.push_back(make_item(FUNC_FLIP, 0, 0, 0, 0, 16'hFFFF));
        // positive extreme coupling
        dir.push_back(make_item(FUNC_WR_YBOND, LAT - 1, LAT - 1, 1, 32767, 0));
        dir.push_back(make_item(FUNC_FLIP, LAT - 1, LAT - 1, 0, 0, 0));
        // tiny change: table head against the top draws
        dir.push_back(make_item(FUNC_WR_XBOND, 5, 5, 0, 1, 0));
        dir.push_back(make_item(FUNC_FLIP, 5, 5, 0, 0, 16'hFFFF));
        dir.push_back(make_item(FUNC_FLIP, 5, 5, 0, 0, 16'hFFFE));
        dir.push_back(make_item(FUNC_WR_SPIN, 5, 5, 1, 0, 0));
        // addresses outside the lattice do nothing
        dir.push_back(make_item(FUNC_FLIP, LAT, 0, 1, 0, 0));
        dir.push_back(make_item(FUNC_WR_SPIN, 0, 15, 0, 0, 0));
        dir.push_back(make_item(FUNC_WR_XBOND, 15, 15, 1, 32767, 16'hFFFF));
        dir.push_back(make_item(FUNC_FLIP, 5, 5, 1, 0, 16'h8000));
        foreach (dir[i])
            send_item(dir[i]);
    endtask

    initial begin
        logic [15:0] betas [N_PHASES];
        sb = new();
        betas = '{16'd4096, 16'd1, 16'd65535, 16'd0, 16'd512, 16'd4096, 16'd0};
        betas[N_PHASES - 1] = 16'($urandom_range(1, 65535));
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_drained();
            write_beta(betas[ph]);
            // one phase runs with no idling on either side
            steady <= (ph == 2);
            if (ph == 0)
                send_directed();
            for (int n = 0; n < RAND_PER_PHASE; n++)
                send_item(random_item());
            s_tvalid <= 1'b0;
        end
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Hard stop for a hung run
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule
